/* hdl/ipv6p_pkg.sv */
// ----------------------------------------------------------------------------
// ipv6p_pkg
// Types shared by the parser front end, the string queue and the expander.
// ----------------------------------------------------------------------------
package ipv6p_pkg;

  localparam int unsigned NumGroups = 8;
  localparam int unsigned GroupW    = 16;

  // one finished string, handed from the front end to the expander
  typedef struct packed {
    logic                                ok;
    logic [3:0]                          n;        // groups collected, tail included
    logic                                gap_seen;
    logic [3:0]                          gap_pos;
    logic [0:NumGroups-1][GroupW-1:0]    groups;   // group 0 in the top bits
  } fin_rec_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

/* hdl/ipv6p_front.sv */
// ----------------------------------------------------------------------------
// ipv6p_front
// Character front end: updates group, gap and IPv4 tail state one byte a cycle
// when accepted; on the final byte it closes the string into a queue record.
// ----------------------------------------------------------------------------
module ipv6p_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         character_i,
  input  logic               last_i,
  output logic               rec_push_o,
  output ipv6p_pkg::fin_rec_t rec_o
);
  import ipv6p_pkg::*;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoF   = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [9:0] DecOver = 10'd256;

  logic [0:NumGroups-1][GroupW-1:0] grp_q, grp_d;
  logic [3:0]  gc_q, gc_d;
  logic [3:0]  gp_q, gp_d;
  logic        gs_q, gs_d;
  logic [15:0] hex_q, hex_d;
  logic [2:0]  dc_q, dc_d;
  logic [9:0]  dec_q, dec_d;
  logic        hl_q, hl_d;
  logic        v4_q, v4_d;
  logic [23:0] oct_q, oct_d;
  logic [1:0]  oi_q, oi_d;
  logic        pwc_q, pwc_d;
  logic        first_q, first_d;
  logic        err_q, err_d;

  logic       is_dig, is_hex;
  logic [3:0] hex_val;

  function automatic logic [9:0] push_dec(input logic [9:0] acc, input logic [3:0] dig);
    logic [11:0] v;
    begin
      v = {2'b00, acc} * 12'd10 + {8'd0, dig};
      push_dec = (v > 12'd255) ? DecOver : v[9:0];
    end
  endfunction

  assign is_dig  = (character_i >= ChZero) && (character_i <= ChNine);
  assign is_hex  = is_dig || ((character_i >= ChLoA) && (character_i <= ChLoF)) ||
                   ((character_i >= ChUpA) && (character_i <= ChUpF));
  assign hex_val = is_dig ? character_i[3:0] : character_i[3:0] + 4'd9;

  // per-character update
  always_comb begin
    grp_d   = grp_q;
    gc_d    = gc_q;
    gp_d    = gp_q;
    gs_d    = gs_q;
    hex_d   = hex_q;
    dc_d    = dc_q;
    dec_d   = dec_q;
    hl_d    = hl_q;
    v4_d    = v4_q;
    oct_d   = oct_q;
    oi_d    = oi_q;
    pwc_d   = pwc_q;
    err_d   = err_q;
    first_d = 1'b0;
    if (!err_q) begin
      if (v4_q) begin
        if (is_dig) begin
          if (dc_q < 3'd7) dc_d = dc_q + 3'd1;
          dec_d = push_dec(dec_q, character_i[3:0]);
        end else if (character_i == ChDot) begin
          if (dc_q == 3'd0 || dec_q > 10'd255 || oi_q == 2'd3) begin
            err_d = 1'b1;
          end else begin
            oct_d = {oct_q[15:0], dec_q[7:0]};
            oi_d  = oi_q + 2'd1;
            hex_d = '0;
            dc_d  = '0;
            dec_d = '0;
            hl_d  = 1'b0;
          end
        end else begin
          err_d = 1'b1;
        end
      end else begin
        if (is_hex) begin
          if (dc_q >= 3'd4 || (pwc_q && gc_q == 4'd0 && !gs_q)) begin
            err_d = 1'b1;
          end else begin
            hex_d = {hex_q[11:0], hex_val};
            dc_d  = dc_q + 3'd1;
            if (is_dig) dec_d = push_dec(dec_q, hex_val);
            else        hl_d  = 1'b1;
            pwc_d = 1'b0;
          end
        end else if (character_i == ChColon) begin
          if (dc_q != 3'd0) begin
            if (gc_q >= 4'd8) begin
              err_d = 1'b1;
            end else begin
              grp_d[gc_q[2:0]] = hex_q;
              gc_d  = gc_q + 4'd1;
              hex_d = '0;
              dc_d  = '0;
              dec_d = '0;
              hl_d  = 1'b0;
              pwc_d = 1'b1;
            end
          end else if (first_q) begin
            pwc_d = 1'b1;
          end else if (pwc_q && !gs_q) begin
            gs_d  = 1'b1;
            gp_d  = gc_q;
            pwc_d = 1'b0;
          end else begin
            err_d = 1'b1;
          end
        end else if (character_i == ChDot) begin
          if (dc_q == 3'd0 || hl_q || dec_q > 10'd255 ||
              !((gc_q == 4'd6 && !gs_q) || (gc_q < 4'd6 && gs_q))) begin
            err_d = 1'b1;
          end else begin
            v4_d  = 1'b1;
            oct_d = {16'd0, dec_q[7:0]};
            oi_d  = 2'd1;
            hex_d = '0;
            dc_d  = '0;
            dec_d = '0;
            hl_d  = 1'b0;
          end
        end else begin
          err_d = 1'b1;
        end
      end
    end
  end

  // close the string on the updated state
  always_comb begin : close_blk
    logic [0:NumGroups-1][GroupW-1:0] g;
    logic [3:0]  n;
    logic        ok;
    logic [31:0] v;
    g  = grp_d;
    n  = gc_d;
    ok = !err_d;
    v  = {oct_d, dec_d[7:0]};
    if (ok && v4_d) begin
      if (dc_d == 3'd0 || dec_d > 10'd255 || oi_d != 2'd3 || n > 4'd6) begin
        ok = 1'b0;
      end else begin
        g[n[2:0]]        = v[31:16];
        g[n[2:0] + 3'd1] = v[15:0];
        n                = n + 4'd2;
      end
    end else if (ok) begin
      if (dc_d != 3'd0) begin
        if (n >= 4'd8) begin
          ok = 1'b0;
        end else begin
          g[n[2:0]] = hex_d;
          n         = n + 4'd1;
        end
      end else if (pwc_d) begin
        ok = 1'b0;
      end
    end
    if (ok && (gs_d ? (n > 4'd7) : (n != 4'd8))) ok = 1'b0;
    rec_o.ok       = ok;
    rec_o.n        = n;
    rec_o.gap_seen = gs_d;
    rec_o.gap_pos  = gp_d;
    rec_o.groups   = g;
  end

  assign rec_push_o = accept_i && last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q   <= '0;
      gc_q    <= '0;
      gp_q    <= '0;
      gs_q    <= 1'b0;
      hex_q   <= '0;
      dc_q    <= '0;
      dec_q   <= '0;
      hl_q    <= 1'b0;
      v4_q    <= 1'b0;
      oct_q   <= '0;
      oi_q    <= '0;
      pwc_q   <= 1'b0;
      first_q <= 1'b1;
      err_q   <= 1'b0;
    end else if (accept_i) begin
      if (last_i) begin
        // back to the start-of-string state
        grp_q   <= '0;
        gc_q    <= '0;
        gp_q    <= '0;
        gs_q    <= 1'b0;
        hex_q   <= '0;
        dc_q    <= '0;
        dec_q   <= '0;
        hl_q    <= 1'b0;
        v4_q    <= 1'b0;
        oct_q   <= '0;
        oi_q    <= '0;
        pwc_q   <= 1'b0;
        first_q <= 1'b1;
        err_q   <= 1'b0;
      end else begin
        grp_q   <= grp_d;
        gc_q    <= gc_d;
        gp_q    <= gp_d;
        gs_q    <= gs_d;
        hex_q   <= hex_d;
        dc_q    <= dc_d;
        dec_q   <= dec_d;
        hl_q    <= hl_d;
        v4_q    <= v4_d;
        oct_q   <= oct_d;
        oi_q    <= oi_d;
        pwc_q   <= pwc_d;
        first_q <= first_d;
        err_q   <= err_d;
      end
    end
  end

endmodule

/* hdl/ipv6p_queue.sv */
// ----------------------------------------------------------------------------
// ipv6p_queue
// Small register queue of finished strings between front end and expander.
// ----------------------------------------------------------------------------
module ipv6p_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ipv6p_pkg::fin_rec_t data_i,
  input  logic                pop_i,
  output ipv6p_pkg::fin_rec_t data_o,
  output ipv6p_pkg::q_stat_t  stat_o
);
  import ipv6p_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  fin_rec_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == FullCnt);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop)      cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

/* hdl/ipv6p_expand.sv */
// ----------------------------------------------------------------------------
// ipv6p_expand
// Back end: opens the gap into zero groups and holds the result register.
// ----------------------------------------------------------------------------
module ipv6p_expand (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ipv6p_pkg::fin_rec_t rec_i,
  input  logic                rec_valid_i,
  output logic                rec_pop_o,
  input  logic                pop,
  output logic                empty,
  output logic                valid_res_o,
  output logic [63:0]         addr_high_o,
  output logic [63:0]         addr_low_o
);
  import ipv6p_pkg::*;

  logic                             vld_q;
  logic                             ok_q;
  logic [2*64-1:0]                  addr_q, addr_d;
  logic [0:NumGroups-1][GroupW-1:0] head_mask, tail_mask;
  logic [3:0]                       gp_eff;
  logic [3:0]                       shift_grp;
  logic [7:0]                       shamt;

  assign gp_eff    = rec_i.gap_seen ? rec_i.gap_pos : 4'd8;
  assign shift_grp = 4'd8 - rec_i.n;
  assign shamt     = {shift_grp, 4'b0000};

  always_comb begin
    for (int k = 0; k < NumGroups; k++) begin
      head_mask[k] = (4'(k) < gp_eff) ? '1 : '0;
      tail_mask[k] = (4'(k) >= gp_eff && 4'(k) < rec_i.n) ? '1 : '0;
    end
    // tail groups slide to the bottom of the address, the gap fills with zeros
    addr_d = (rec_i.groups & head_mask) | ((rec_i.groups & tail_mask) >> shamt);
    if (!rec_i.ok) addr_d = '0;
  end

  assign rec_pop_o   = rec_valid_i && (!vld_q || pop);
  assign empty       = !vld_q;
  assign valid_res_o = ok_q;
  assign addr_high_o = addr_q[127:64];
  assign addr_low_o  = addr_q[63:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rec_pop_o) begin
      vld_q <= 1'b1;
    end else if (pop) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      ok_q   <= rec_i.ok;
      addr_q <= addr_d;
    end
  end

endmodule

/* hdl/ipv6_text_address_parser_core.sv */
// ----------------------------------------------------------------------------
// ipv6_text_address_parser_core
// Path: the final character's record enters the string queue as the character
// is accepted, then the result register once that is empty or being popped.
// Throughput: one character per cycle while the queue (QDepth deep, two by
// default) is not full; one result per cycle while results are popped.
// Reset: asynchronous; clears parser state, queue pointers, result valid flag.
// ----------------------------------------------------------------------------
module ipv6_text_address_parser_core #(
  parameter int unsigned QDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  character_i,
  input  logic        last_i,
  output logic        empty,
  input  logic        pop,
  output logic        valid_res_o,
  output logic [63:0] addr_high_o,
  output logic [63:0] addr_low_o
);
  import ipv6p_pkg::*;

  fin_rec_t fin_rec, q_rec;
  q_stat_t  q_stat;
  logic     rec_push, rec_pop, accept;

  assign full   = q_stat.full;
  assign accept = push && !full;

  ipv6p_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .character_i (character_i),
    .last_i      (last_i),
    .rec_push_o  (rec_push),
    .rec_o       (fin_rec)
  );

  ipv6p_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rec_push),
    .data_i (fin_rec),
    .pop_i  (rec_pop),
    .data_o (q_rec),
    .stat_o (q_stat)
  );

  ipv6p_expand u_expand (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (q_rec),
    .rec_valid_i (!q_stat.empty),
    .rec_pop_o   (rec_pop),
    .pop         (pop),
    .empty       (empty),
    .valid_res_o (valid_res_o),
    .addr_high_o (addr_high_o),
    .addr_low_o  (addr_low_o)
  );

endmodule

/* hdl/ipv6p_checker.sv */
// ----------------------------------------------------------------------------
// ipv6p_checker
// Port-level parser checks: reset state, result hold, zero reject, queue fill.
// ----------------------------------------------------------------------------
module ipv6p_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic [7:0]  character_i,
  input logic        last_i,
  input logic        empty,
  input logic        pop,
  input logic        valid_res_o,
  input logic [63:0] addr_high_o,
  input logic [63:0] addr_low_o
);

  // no result waits and the queue is not full while reset is held
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> (empty && !full))
    else $error("result or full flag set during reset");

  // a waiting result holds until it is taken
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(valid_res_o) &&
                          $stable(addr_high_o) && $stable(addr_low_o)))
    else $error("waiting result changed before pop");

  // a rejected string carries an all-zero address
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !valid_res_o) |-> (addr_high_o == 64'd0 && addr_low_o == 64'd0))
    else $error("invalid result with non-zero address");

  // the queue only fills on a finished string
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && last_i))
    else $error("full raised without a final character request");

  // the character itself only matters to the parser, not to these checks
  logic unused_char;
  assign unused_char = ^character_i;

endmodule

bind ipv6_text_address_parser_core ipv6p_checker u_ipv6p_checker (.*);
